@@ sv/dlrs_pkg.sv @@
// Shared constants and types for the decimal LSD radix sorter.
package dlrs_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int VW          = 10;
	localparam int AW          = $clog2(MAX_ITEMS);
	localparam int CW          = $clog2(MAX_ITEMS + 1);
	localparam int RADIX       = 10;
	localparam int DGW         = 4;
	localparam int PW          = 2;
	localparam int DIV10_MUL   = 205;
	localparam int DIV10_SHIFT = 11;
	localparam int PRODW       = VW + 8;

	typedef struct packed {
		logic [VW-1:0] key;
		logic [VW-1:0] val;
	} entry_t;

	typedef struct packed {
		logic [VW-1:0]  quot;
		logic [DGW-1:0] digit;
	} digit_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_COUNT    = 6'b000010,
		ST_PREFIX   = 6'b000100,
		ST_SCATTER  = 6'b001000,
		ST_OUT_RD   = 6'b010000,
		ST_OUT_SHOW = 6'b100000
	} state_t;

endpackage

@@ sv/dlrs_digit.sv @@
// Divide-by-ten unit: splits a key into its low decimal digit and the remaining quotient.
module dlrs_digit (
	input  logic [dlrs_pkg::VW-1:0] key,
	output dlrs_pkg::digit_t        res
);

	logic [dlrs_pkg::PRODW-1:0] prod;
	logic [dlrs_pkg::VW-1:0]    quot;
	logic [dlrs_pkg::VW-1:0]    back;

	assign prod = dlrs_pkg::PRODW'(key) * dlrs_pkg::PRODW'(dlrs_pkg::DIV10_MUL);
	assign quot = dlrs_pkg::VW'(prod >> dlrs_pkg::DIV10_SHIFT);
	assign back = dlrs_pkg::VW'(quot * dlrs_pkg::VW'(dlrs_pkg::RADIX));

	assign res.quot  = quot;
	assign res.digit = dlrs_pkg::DGW'(key - back);

endmodule

@@ sv/decimal_lsd_radix_sort.sv @@
// Top level of the decimal LSD radix sorter: load store, sequencer, bucket counters, output.
//
// Values are loaded one beat per cycle into a 64-entry store; extra values are dropped. The
// beat with last set closes the set and the block stops taking input until the whole sorted
// set has been delivered. Each digit pass counts buckets, forms the bucket offsets and then
// scatters the values into the other store, all through a single divide-by-ten unit and one
// read port per store. Output reads each value from the store, then shows it until it is
// taken. A pass count of zero written through cfg_data sorts one digit.
module decimal_lsd_radix_sort (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [dlrs_pkg::PW-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [dlrs_pkg::VW-1:0] value,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [dlrs_pkg::VW-1:0] sorted_value,
	output logic                    last_out
);

	dlrs_pkg::state_t state_q;
	logic [dlrs_pkg::PW-1:0]  passes_q;
	logic [dlrs_pkg::PW-1:0]  pass_q;
	logic [dlrs_pkg::PW-1:0]  passes_eff;
	logic [dlrs_pkg::CW-1:0]  loaded_q;
	logic [dlrs_pkg::CW-1:0]  i_q;
	logic [dlrs_pkg::DGW-1:0] bidx_q;
	logic [dlrs_pkg::CW-1:0]  sum_q;
	logic                     src_q;
	logic                     rv_s1;
	logic [dlrs_pkg::CW-1:0]  cnt_q [dlrs_pkg::RADIX];

	dlrs_pkg::entry_t mem_a [dlrs_pkg::MAX_ITEMS];
	dlrs_pkg::entry_t mem_b [dlrs_pkg::MAX_ITEMS];
	dlrs_pkg::entry_t rd_a_q;
	dlrs_pkg::entry_t rd_b_q;
	dlrs_pkg::entry_t rec;
	dlrs_pkg::entry_t wr_data;
	dlrs_pkg::digit_t dig;

	logic                    in_acc;
	logic                    has_room;
	logic                    i_done;
	logic                    last_pass;
	logic                    clr;
	logic                    bump;
	logic                    scat_wr;
	logic                    wr_a;
	logic                    wr_b;
	logic [dlrs_pkg::AW-1:0] wr_addr;
	logic [dlrs_pkg::AW-1:0] rd_addr;
	logic [dlrs_pkg::CW-1:0] cnt_dig;
	logic [dlrs_pkg::CW-1:0] cnt_bidx;
	logic                    out_last;

	assign in_stall   = (state_q != dlrs_pkg::ST_IDLE);
	assign in_acc     = in_valid && (state_q == dlrs_pkg::ST_IDLE);
	assign has_room   = (loaded_q < dlrs_pkg::CW'(dlrs_pkg::MAX_ITEMS));
	assign i_done     = (i_q == loaded_q);
	assign passes_eff = (passes_q == '0) ? dlrs_pkg::PW'(1) : passes_q;
	assign last_pass  = (pass_q == dlrs_pkg::PW'(passes_eff - 1'b1));
	assign out_last   = (i_q == dlrs_pkg::CW'(loaded_q - 1'b1));

	assign clr = (in_acc && last) ||
		((state_q == dlrs_pkg::ST_SCATTER) && i_done && !last_pass);

	assign rec = src_q ? rd_b_q : rd_a_q;

	dlrs_digit u_digit (
		.key (rec.key),
		.res (dig)
	);

	assign cnt_dig  = (dig.digit < dlrs_pkg::DGW'(dlrs_pkg::RADIX)) ? cnt_q[dig.digit] : '0;
	assign cnt_bidx = (bidx_q < dlrs_pkg::DGW'(dlrs_pkg::RADIX)) ? cnt_q[bidx_q] : '0;

	assign bump    = rv_s1 &&
		((state_q == dlrs_pkg::ST_COUNT) || (state_q == dlrs_pkg::ST_SCATTER));
	assign scat_wr = rv_s1 && (state_q == dlrs_pkg::ST_SCATTER);

	always_comb begin
		if (state_q == dlrs_pkg::ST_IDLE) begin
			wr_addr     = loaded_q[dlrs_pkg::AW-1:0];
			wr_data.key = value;
			wr_data.val = value;
		end else begin
			wr_addr     = cnt_dig[dlrs_pkg::AW-1:0];
			wr_data.key = dig.quot;
			wr_data.val = rec.val;
		end
	end

	assign wr_a    = (in_acc && has_room) || (scat_wr && src_q);
	assign wr_b    = scat_wr && !src_q;
	assign rd_addr = i_q[dlrs_pkg::AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_a[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr] <= wr_data;
		end
		rd_b_q <= mem_b[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passes_q <= dlrs_pkg::PW'(3);
		end else if (cfg_we) begin
			passes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < dlrs_pkg::RADIX; b++) begin
				cnt_q[b] <= '0;
			end
		end else begin
			for (int b = 0; b < dlrs_pkg::RADIX; b++) begin
				if (clr) begin
					cnt_q[b] <= '0;
				end else if ((state_q == dlrs_pkg::ST_PREFIX) &&
						(bidx_q == dlrs_pkg::DGW'(b))) begin
					cnt_q[b] <= sum_q;
				end else if (bump && (dig.digit == dlrs_pkg::DGW'(b))) begin
					cnt_q[b] <= dlrs_pkg::CW'(cnt_q[b] + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= ((state_q == dlrs_pkg::ST_COUNT) || (state_q == dlrs_pkg::ST_SCATTER))
				&& !i_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dlrs_pkg::ST_IDLE;
			loaded_q <= '0;
			i_q      <= '0;
			pass_q   <= '0;
			bidx_q   <= '0;
			sum_q    <= '0;
			src_q    <= 1'b0;
		end else begin
			case (state_q)
				dlrs_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (has_room) begin
							loaded_q <= dlrs_pkg::CW'(loaded_q + 1'b1);
						end
						if (last) begin
							state_q <= dlrs_pkg::ST_COUNT;
							i_q     <= '0;
							pass_q  <= '0;
							src_q   <= 1'b0;
						end
					end
				end
				dlrs_pkg::ST_COUNT: begin
					if (!i_done) begin
						i_q <= dlrs_pkg::CW'(i_q + 1'b1);
					end else begin
						state_q <= dlrs_pkg::ST_PREFIX;
						bidx_q  <= '0;
						sum_q   <= '0;
					end
				end
				dlrs_pkg::ST_PREFIX: begin
					sum_q <= dlrs_pkg::CW'(sum_q + cnt_bidx);
					if (bidx_q == dlrs_pkg::DGW'(dlrs_pkg::RADIX - 1)) begin
						state_q <= dlrs_pkg::ST_SCATTER;
						i_q     <= '0;
					end else begin
						bidx_q <= dlrs_pkg::DGW'(bidx_q + 1'b1);
					end
				end
				dlrs_pkg::ST_SCATTER: begin
					if (!i_done) begin
						i_q <= dlrs_pkg::CW'(i_q + 1'b1);
					end else begin
						src_q <= !src_q;
						i_q   <= '0;
						if (last_pass) begin
							state_q <= dlrs_pkg::ST_OUT_RD;
						end else begin
							pass_q  <= dlrs_pkg::PW'(pass_q + 1'b1);
							state_q <= dlrs_pkg::ST_COUNT;
						end
					end
				end
				dlrs_pkg::ST_OUT_RD: begin
					state_q <= dlrs_pkg::ST_OUT_SHOW;
				end
				dlrs_pkg::ST_OUT_SHOW: begin
					if (!out_stall) begin
						if (out_last) begin
							state_q  <= dlrs_pkg::ST_IDLE;
							loaded_q <= '0;
							i_q      <= '0;
						end else begin
							i_q     <= dlrs_pkg::CW'(i_q + 1'b1);
							state_q <= dlrs_pkg::ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= dlrs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = (state_q == dlrs_pkg::ST_OUT_SHOW);
	assign sorted_value = rec.val;
	assign last_out     = out_last;

endmodule

@@ sv/dlrs_chk.sv @@
// Port-level checker for the decimal LSD radix sorter, bound to the top level.
module dlrs_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    last,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [dlrs_pkg::VW-1:0] sorted_value,
	input logic                    last_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(last_out))
		else $error("stalled output beat changed");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while results pending");

	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall && !out_valid)
		else $error("closing beat did not start the sort");

	a_end_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_out |=> !out_valid && !in_stall)
		else $error("block not idle after final beat");

endmodule

bind decimal_lsd_radix_sort dlrs_chk u_chk (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for decimal_lsd_radix_sort: directed and random sets, stable radix predictor, scoreboard.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 4000;
	localparam int SETTLE      = 20;
	localparam int N_PHASES    = 10;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [dlrs_pkg::VW-1:0] val;
		logic                    fin;
	} sort_beat_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [dlrs_pkg::PW-1:0] cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [dlrs_pkg::VW-1:0] value     = '0;
	logic                    last      = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [dlrs_pkg::VW-1:0] sorted_value;
	logic                    last_out;

	sort_beat_t              load_q[$];
	sort_beat_t              sorted_q[$];
	logic [dlrs_pkg::VW-1:0] held_q[$];
	logic [dlrs_pkg::PW-1:0] passes_reg = dlrs_pkg::PW'(3);

	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;
	int   n_queued   = 0;
	int   n_accepted = 0;
	int   err_count  = 0;
	int   stuck      = 0;
	int   send_idle_pct = 10;
	int   recv_idle_pct = 85;

	decimal_lsd_radix_sort i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_out     (last_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int decimal_digit(input logic [dlrs_pkg::VW-1:0] v, input int pos);
		int q;
		q = int'(v);
		for (int k = 0; k < pos; k++)
			q = q / 10;
		return q % 10;
	endfunction

	function automatic void radix_sort_held();
		logic [dlrs_pkg::VW-1:0] src[$];
		logic [dlrs_pkg::VW-1:0] dst[$];
		int                      n_passes;
		n_passes = (passes_reg == 0) ? 1 : int'(passes_reg);
		src = held_q;
		for (int p = 0; p < n_passes; p++) begin
			dst.delete();
			for (int d = 0; d < 10; d++)
				foreach (src[i])
					if (decimal_digit(src[i], p) == d)
						dst.push_back(src[i]);
			src = dst;
		end
		foreach (src[i])
			sorted_q.push_back('{val: src[i], fin: (i == src.size() - 1)});
		held_q.delete();
	endfunction

	always @(negedge clk) begin
		sort_beat_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			if (!in_valid || in_taken) begin
				if (load_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = load_q.pop_front();
					in_valid <= 1'b1;
					value    <= nxt.val;
					last     <= nxt.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		sort_beat_t exp_beat;
		in_taken  = in_valid && !in_stall;
		out_taken = out_valid && !out_stall;
		if (arst_n) begin
			if (cfg_we)
				passes_reg = cfg_data;
			if (out_taken) begin
				if (sorted_q.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("unexpected beat: sorted_value=%0d last_out=%0b",
							sorted_value, last_out);
				end else begin
					exp_beat = sorted_q.pop_front();
					if (sorted_value !== exp_beat.val || last_out !== exp_beat.fin) begin
						err_count++;
						if (err_count <= REPORT_MAX)
							$display("mismatch: sorted_value exp %0d got %0d, last_out exp %0b got %0b",
								exp_beat.val, sorted_value, exp_beat.fin, last_out);
					end
				end
			end
			if (in_taken) begin
				n_accepted++;
				if (held_q.size() < dlrs_pkg::MAX_ITEMS)
					held_q.push_back(value);
				if (last)
					radix_sort_held();
			end
			if (in_taken || out_taken)
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic queue_beat(input logic [dlrs_pkg::VW-1:0] v, input logic fin);
		load_q.push_back('{val: v, fin: fin});
		n_queued++;
	endtask

	task automatic queue_set(input int sz);
		int r;
		logic [dlrs_pkg::VW-1:0] v;
		for (int i = 0; i < sz; i++) begin
			r = $urandom_range(0, 3);
			case (r)
				0: v = dlrs_pkg::VW'($urandom_range(0, 1023));
				1: v = dlrs_pkg::VW'($urandom_range(0, 30));
				default: v = dlrs_pkg::VW'($urandom_range(0, 999));
			endcase
			queue_beat(v, i == sz - 1);
		end
	endtask

	task automatic queue_directed();
		queue_beat(10'd0, 1'b1);
		queue_beat(10'd1023, 1'b0);
		queue_beat(10'd999, 1'b0);
		queue_beat(10'd0, 1'b0);
		queue_beat(10'd512, 1'b0);
		queue_beat(10'd1000, 1'b0);
		queue_beat(10'd7, 1'b1);
		queue_beat(10'd5, 1'b0);
		queue_beat(10'd5, 1'b0);
		queue_beat(10'd5, 1'b1);
		queue_beat(10'd321, 1'b0);
		queue_beat(10'd123, 1'b0);
		queue_beat(10'd213, 1'b0);
		queue_beat(10'd312, 1'b0);
		queue_beat(10'd132, 1'b0);
		queue_beat(10'd231, 1'b1);
		queue_beat(10'd10, 1'b0);
		queue_beat(10'd1, 1'b0);
		queue_beat(10'd100, 1'b0);
		queue_beat(10'd11, 1'b0);
		queue_beat(10'd101, 1'b0);
		queue_beat(10'd110, 1'b0);
		queue_beat(10'd0, 1'b0);
		queue_beat(10'd1010, 1'b1);
	endtask

	task automatic write_passes(input logic [dlrs_pkg::PW-1:0] p);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = p;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_accepted != n_queued || sorted_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [dlrs_pkg::PW-1:0] phase_passes[N_PHASES];
		int                      start_cnt;
		phase_passes = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_passes(phase_passes[ph]);
			@(posedge clk);
			if (ph < 4) begin
				send_idle_pct = 10;
				recv_idle_pct = 85;
			end else if (ph < 7) begin
				send_idle_pct = 85;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 0) begin
				queue_directed();
			end else begin
				start_cnt = n_queued;
				if (ph == 2)
					queue_set(dlrs_pkg::MAX_ITEMS);
				else if (ph == 5)
					queue_set(dlrs_pkg::MAX_ITEMS + 1);
				else if (ph == 8)
					queue_set(dlrs_pkg::MAX_ITEMS + $urandom_range(2, 8));
				while (n_queued - start_cnt < 30)
					queue_set($urandom_range(1, 12));
			end
			wait_drained();
		end
		if (err_count == 0 && sorted_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ decimal_lsd_radix_sort.f @@
sv/dlrs_pkg.sv
sv/dlrs_digit.sv
sv/decimal_lsd_radix_sort.sv
sv/dlrs_chk.sv
sim/testbench.sv
